FILE: src/cartridge_bank_mapper_with_irq_top_defines.svh
// Assertion macros for the cartridge bank mapper.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_TOP_DEFINES_SVH

// Checked on the rising clock, ignored while reset is high.
`define CBM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock, reset included.
`define CBM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/cbm_pkg.sv
// Shared types, codes and constants for the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

   localparam int unsigned PRESCALE_PERIOD = 341;
   localparam int unsigned PRESCALE_STEP   = 3;
   localparam int unsigned CHR_BANKS       = 8;
   localparam int unsigned CHR_IDX_W       = $clog2(CHR_BANKS);
   localparam int unsigned PRESC_W         = 10;

   localparam int unsigned CMD_W      = 3;
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned DATA_W     = 8;
   localparam int unsigned TARGET_W   = 3;
   localparam int unsigned MAPPED_W   = 18;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 6;

   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CPU_RD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CPU_WR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PPU_RD = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PPU_WR = 3'd4;

   localparam logic [TARGET_W-1:0] TGT_NONE    = 3'd0;
   localparam logic [TARGET_W-1:0] TGT_PRG_ROM = 3'd1;
   localparam logic [TARGET_W-1:0] TGT_PRG_RAM = 3'd2;
   localparam logic [TARGET_W-1:0] TGT_CHR_ROM = 3'd3;
   localparam logic [TARGET_W-1:0] TGT_CHR_RAM = 3'd4;
   localparam logic [TARGET_W-1:0] TGT_CIRAM   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_A0_PIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A1_PIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_BANKS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_KIND   = 2'd3;

   localparam logic [1:0] CHR_KIND_ROM = 2'd0;
   localparam logic [1:0] CHR_KIND_RAM = 2'd1;

   localparam logic [3:0] PAGE_PRG0      = 4'h8;
   localparam logic [3:0] PAGE_MIRROR    = 4'h9;
   localparam logic [3:0] PAGE_PRG1      = 4'ha;
   localparam logic [3:0] PAGE_CHR_FIRST = 4'hb;
   localparam logic [3:0] PAGE_CHR_1     = 4'hc;
   localparam logic [3:0] PAGE_CHR_2     = 4'hd;
   localparam logic [3:0] PAGE_CHR_LAST  = 4'he;
   localparam logic [3:0] PAGE_IRQ       = 4'hf;

   localparam logic [1:0] SEL_LATCH_LO = 2'd0;
   localparam logic [1:0] SEL_LATCH_HI = 2'd1;
   localparam logic [1:0] SEL_CTRL     = 2'd2;
   localparam logic [1:0] SEL_ACK      = 2'd3;

   localparam logic [1:0] MIR_VERT = 2'd0;
   localparam logic [1:0] MIR_HORZ = 2'd1;
   localparam logic [1:0] MIR_ONE0 = 2'd2;
   localparam logic [1:0] MIR_ONE1 = 2'd3;

   typedef struct packed {
      logic              tick;
      logic              wr_latch_lo;
      logic              wr_latch_hi;
      logic              wr_ctrl;
      logic              wr_ack;
      logic [DATA_W-1:0] data;
   } cbm_irq_ctl_type;

   typedef struct packed {
      logic pending;
      logic pending_next;
   } cbm_irq_stat_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [MAPPED_W-1:0] mapped_address;
      logic                irq_line;
   } cbm_rsp_type;

endpackage
`default_nettype wire

FILE: src/cbm_if.sv
// Request and response channel interfaces for the cartridge bank mapper.
`default_nettype none
interface cbm_req_if;
   logic                        valid;
   logic                        ready;
   logic [cbm_pkg::CMD_W-1:0]   cmd;
   logic [cbm_pkg::ADDR_W-1:0]  address;
   logic [cbm_pkg::DATA_W-1:0]  data;

   modport source (output valid, output cmd, output address, output data, input ready);
   modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

interface cbm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cbm_pkg::TARGET_W-1:0] target;
   logic [cbm_pkg::MAPPED_W-1:0] mapped_address;
   logic                         irq_line;

   modport source (output valid, output target, output mapped_address, output irq_line,
                   input ready);
   modport sink   (input valid, input target, input mapped_address, input irq_line,
                   output ready);
endinterface
`default_nettype wire

FILE: src/cartridge_bank_mapper_with_irq_top.sv
// Cartridge bank mapper with IRQ counter: decode, bank registers and response buffer.
//
//   channel   dir   handshake       beat contents
//   req_bus   in    valid/ready     cmd, address, data
//   rsp_bus   out   valid/ready     target, mapped_address, irq_line
//   csr_*     in    csr_wr_en only  csr_index, csr_wr_data
//
// One beat per cycle while ready is high; responses are held in the output register.
// Decode, bank lookup and IRQ update all sit between the request port and that register.
// A skid register behind the output keeps req_bus.ready high for one stalled response;
// ready drops only while the skid register is full.
// Reset is synchronous; it clears all state but the response data registers.
`default_nettype none
`include "cartridge_bank_mapper_with_irq_top_defines.svh"
module cartridge_bank_mapper_with_irq_top #(
   parameter int unsigned PrescalePeriod = cbm_pkg::PRESCALE_PERIOD,
   parameter int unsigned PrescaleStep   = cbm_pkg::PRESCALE_STEP
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   cbm_req_if.sink                          req_bus,
   cbm_rsp_if.source                        rsp_bus
);

   localparam int unsigned CIW = cbm_pkg::CHR_IDX_W;

   // configuration
   logic [2:0] a0_pin_ff, a0_pin_in;
   logic [2:0] a1_pin_ff, a1_pin_in;
   logic [5:0] prg_count_ff, prg_count_in;
   logic [1:0] chr_kind_ff, chr_kind_in;

   // mapper state
   logic       prg_mode_ff, prg_mode_in;
   logic [4:0] prg_bank_ff [2];
   logic [4:0] prg_bank_in [2];
   logic [1:0] mirroring_ff, mirroring_in;
   logic [7:0] chr_bank_ff [cbm_pkg::CHR_BANKS];
   logic [7:0] chr_bank_in [cbm_pkg::CHR_BANKS];

   // output register and skid
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   cbm_pkg::cbm_rsp_type out_ff, out_in;
   cbm_pkg::cbm_rsp_type skid_ff, skid_in;
   cbm_pkg::cbm_rsp_type rsp_new;

   logic                      accept;
   logic                      reg_wr;
   logic [1:0]                sel;
   logic [3:0]                page;
   logic [3:0]                chr_page_off;
   logic [CIW-1:0]            chr_wr_idx;
   logic [13:0]               paddr;
   logic [4:0]                bank_last;
   logic [4:0]                bank_second_last;
   logic [4:0]                prg_sel;
   logic [10:0]               ciram_addr;
   logic [7:0]                chr_sel;
   cbm_pkg::cbm_irq_ctl_type  irq_ctl;
   cbm_pkg::cbm_irq_stat_type irq_stat;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !skid_valid_ff;

   assign sel          = {req_bus.address[a1_pin_ff], req_bus.address[a0_pin_ff]};
   assign page         = req_bus.address[15:12];
   assign reg_wr       = accept && (req_bus.cmd == cbm_pkg::CMD_CPU_WR) && req_bus.address[15];
   assign chr_page_off = page - cbm_pkg::PAGE_CHR_FIRST;
   assign chr_wr_idx   = {chr_page_off[1:0], sel[1]};
   assign paddr        = req_bus.address[13:0];

   always_comb begin
      a0_pin_in    = a0_pin_ff;
      a1_pin_in    = a1_pin_ff;
      prg_count_in = prg_count_ff;
      chr_kind_in  = chr_kind_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cbm_pkg::CSR_A0_PIN:    a0_pin_in    = csr_wr_data[2:0];
            cbm_pkg::CSR_A1_PIN:    a1_pin_in    = csr_wr_data[2:0];
            cbm_pkg::CSR_PRG_BANKS: prg_count_in = csr_wr_data;
            cbm_pkg::CSR_CHR_KIND:  chr_kind_in  = csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prg_mode_in  = prg_mode_ff;
      prg_bank_in  = prg_bank_ff;
      mirroring_in = mirroring_ff;
      chr_bank_in  = chr_bank_ff;
      irq_ctl      = '0;
      irq_ctl.data = req_bus.data;
      irq_ctl.tick = accept && (req_bus.cmd == cbm_pkg::CMD_TICK);
      if (reg_wr) begin
         unique case (page) inside
            cbm_pkg::PAGE_PRG0: prg_bank_in[0] = req_bus.data[4:0];
            cbm_pkg::PAGE_MIRROR: begin
               if (!sel[1]) begin
                  mirroring_in = req_bus.data[1:0];
               end else begin
                  prg_mode_in = req_bus.data[1];
               end
            end
            cbm_pkg::PAGE_PRG1: prg_bank_in[1] = req_bus.data[4:0];
            cbm_pkg::PAGE_CHR_FIRST, cbm_pkg::PAGE_CHR_1,
            cbm_pkg::PAGE_CHR_2, cbm_pkg::PAGE_CHR_LAST: begin
               if (sel[0]) begin
                  chr_bank_in[chr_wr_idx] = {req_bus.data[3:0], chr_bank_ff[chr_wr_idx][3:0]};
               end else begin
                  chr_bank_in[chr_wr_idx] = {chr_bank_ff[chr_wr_idx][7:4], req_bus.data[3:0]};
               end
            end
            cbm_pkg::PAGE_IRQ: begin
               unique case (sel)
                  cbm_pkg::SEL_LATCH_LO: irq_ctl.wr_latch_lo = 1'b1;
                  cbm_pkg::SEL_LATCH_HI: irq_ctl.wr_latch_hi = 1'b1;
                  cbm_pkg::SEL_CTRL:     irq_ctl.wr_ctrl     = 1'b1;
                  cbm_pkg::SEL_ACK:      irq_ctl.wr_ack      = 1'b1;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   cbm_irq #(
      .PrescalePeriod (PrescalePeriod),
      .PrescaleStep   (PrescaleStep)
   ) u_irq (
      .clock (clock),
      .reset (reset),
      .ctl   (irq_ctl),
      .stat  (irq_stat)
   );

   // address translation
   assign bank_last        = prg_count_ff[4:0] - 5'd1;
   assign bank_second_last = prg_count_ff[4:0] - 5'd2;
   assign chr_sel          = chr_bank_ff[paddr[12:10]];

   always_comb begin
      case (req_bus.address[14:13])
         2'b00:   prg_sel = prg_mode_ff ? bank_second_last : prg_bank_ff[0];
         2'b01:   prg_sel = prg_bank_ff[1];
         2'b10:   prg_sel = prg_mode_ff ? prg_bank_ff[0] : bank_second_last;
         default: prg_sel = bank_last;
      endcase
   end

   always_comb begin
      unique case (mirroring_ff)
         cbm_pkg::MIR_VERT: ciram_addr = {paddr[10], paddr[9:0]};
         cbm_pkg::MIR_HORZ: ciram_addr = {paddr[11], paddr[9:0]};
         cbm_pkg::MIR_ONE0: ciram_addr = {1'b0, paddr[9:0]};
         cbm_pkg::MIR_ONE1: ciram_addr = {1'b1, paddr[9:0]};
         default:           ciram_addr = {1'b0, paddr[9:0]};
      endcase
   end

   always_comb begin
      rsp_new.target         = cbm_pkg::TGT_NONE;
      rsp_new.mapped_address = '0;
      rsp_new.irq_line       = irq_stat.pending_next;
      unique case (req_bus.cmd)
         cbm_pkg::CMD_CPU_RD, cbm_pkg::CMD_CPU_WR: begin
            if (req_bus.address[15:13] == 3'b011) begin
               rsp_new.target         = cbm_pkg::TGT_PRG_RAM;
               rsp_new.mapped_address = {5'd0, req_bus.address[12:0]};
            end else if (req_bus.address[15] && (req_bus.cmd == cbm_pkg::CMD_CPU_RD)) begin
               rsp_new.target         = cbm_pkg::TGT_PRG_ROM;
               rsp_new.mapped_address = {prg_sel, req_bus.address[12:0]};
            end
         end
         cbm_pkg::CMD_PPU_RD, cbm_pkg::CMD_PPU_WR: begin
            if (paddr[13]) begin
               rsp_new.target         = cbm_pkg::TGT_CIRAM;
               rsp_new.mapped_address = {7'd0, ciram_addr};
            end else if ((chr_kind_ff == cbm_pkg::CHR_KIND_ROM)
                         && (req_bus.cmd == cbm_pkg::CMD_PPU_RD)) begin
               rsp_new.target         = cbm_pkg::TGT_CHR_ROM;
               rsp_new.mapped_address = {chr_sel, paddr[9:0]};
            end else if (chr_kind_ff == cbm_pkg::CHR_KIND_RAM) begin
               rsp_new.target         = cbm_pkg::TGT_CHR_RAM;
               rsp_new.mapped_address = {chr_sel, paddr[9:0]};
            end
         end
         default: ;
      endcase
   end

   // response register with skid
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         out_valid_in  = skid_valid_ff || accept;
         skid_valid_in = 1'b0;
         out_in        = skid_valid_ff ? skid_ff : rsp_new;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_pin_ff     <= 3'd0;
         a1_pin_ff     <= 3'd1;
         prg_count_ff  <= 6'd32;
         chr_kind_ff   <= cbm_pkg::CHR_KIND_ROM;
         prg_mode_ff   <= 1'b0;
         prg_bank_ff   <= '{default: '0};
         mirroring_ff  <= cbm_pkg::MIR_VERT;
         chr_bank_ff   <= '{default: '0};
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         a0_pin_ff     <= a0_pin_in;
         a1_pin_ff     <= a1_pin_in;
         prg_count_ff  <= prg_count_in;
         chr_kind_ff   <= chr_kind_in;
         prg_mode_ff   <= prg_mode_in;
         prg_bank_ff   <= prg_bank_in;
         mirroring_ff  <= mirroring_in;
         chr_bank_ff   <= chr_bank_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.target         = out_ff.target;
   assign rsp_bus.mapped_address = out_ff.mapped_address;
   assign rsp_bus.irq_line       = out_ff.irq_line;

   `CBM_ASSERT(a_skid_catches_stall, (out_valid_ff && !rsp_bus.ready && accept) |=> skid_valid_ff, "stalled beat not held in skid")
   `CBM_ASSERT(a_irq_rise_on_tick, $rose(irq_stat.pending) |-> $past(accept && (req_bus.cmd == cbm_pkg::CMD_TICK)), "IRQ raised without a tick")
   `CBM_ASSERT(a_none_maps_zero, (out_valid_ff && (out_ff.target == cbm_pkg::TGT_NONE)) |-> (out_ff.mapped_address == '0), "unmapped beat carries an address")
   `CBM_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_ff |-> out_valid_ff, "skid full with output empty")

endmodule
`default_nettype wire

FILE: src/cbm_irq.sv
// IRQ latch, counter, prescaler and pending flag.
`default_nettype none
module cbm_irq #(
   parameter int unsigned PrescalePeriod = cbm_pkg::PRESCALE_PERIOD,
   parameter int unsigned PrescaleStep   = cbm_pkg::PRESCALE_STEP
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cbm_pkg::cbm_irq_ctl_type  ctl,
   output cbm_pkg::cbm_irq_stat_type stat
);

   localparam int unsigned PW = cbm_pkg::PRESC_W;
   localparam logic signed [PW:0] PRESC_SAT = -$signed((PW + 1)'(2 ** (PW - 1)));

   logic [7:0]           latch_ff, latch_in;
   logic                 cycle_mode_ff, cycle_mode_in;
   logic                 enabled_ff, enabled_in;
   logic                 ack_en_ff, ack_en_in;
   logic [7:0]           count_ff, count_in;
   logic signed [PW-1:0] presc_ff, presc_in;
   logic                 pending_ff, pending_in;

   logic signed [PW:0]   presc_dec;
   logic signed [PW:0]   presc_wrap;
   logic                 count_clk;

   always_comb begin
      latch_in      = latch_ff;
      cycle_mode_in = cycle_mode_ff;
      enabled_in    = enabled_ff;
      ack_en_in     = ack_en_ff;
      count_in      = count_ff;
      presc_in      = presc_ff;
      pending_in    = pending_ff;
      count_clk     = 1'b0;

      presc_dec  = {presc_ff[PW-1], presc_ff} - $signed((PW + 1)'(PrescaleStep));
      presc_wrap = presc_dec + $signed((PW + 1)'(PrescalePeriod));
      if (presc_wrap < PRESC_SAT) begin
         presc_wrap = PRESC_SAT;
      end

      if (ctl.tick && enabled_ff) begin
         if (cycle_mode_ff) begin
            count_clk = 1'b1;
         end else if (presc_dec <= 0) begin
            presc_in  = presc_wrap[PW-1:0];
            count_clk = 1'b1;
         end else begin
            presc_in = presc_dec[PW-1:0];
         end
      end

      if (count_clk) begin
         if (count_ff == 8'hff) begin
            count_in   = latch_ff;
            pending_in = 1'b1;
         end else begin
            count_in = count_ff + 8'd1;
         end
      end

      if (ctl.wr_latch_lo) begin
         latch_in = {latch_ff[7:4], ctl.data[3:0]};
      end
      if (ctl.wr_latch_hi) begin
         latch_in = {ctl.data[3:0], latch_ff[3:0]};
      end
      if (ctl.wr_ctrl) begin
         ack_en_in     = ctl.data[0];
         enabled_in    = ctl.data[1];
         cycle_mode_in = ctl.data[2];
         if (ctl.data[1]) begin
            count_in = latch_ff;
            presc_in = PW'(PrescalePeriod);
         end
         pending_in = 1'b0;
      end
      if (ctl.wr_ack) begin
         enabled_in = ack_en_ff;
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff      <= '0;
         cycle_mode_ff <= 1'b0;
         enabled_ff    <= 1'b0;
         ack_en_ff     <= 1'b0;
         count_ff      <= '0;
         presc_ff      <= '0;
         pending_ff    <= 1'b0;
      end else begin
         latch_ff      <= latch_in;
         cycle_mode_ff <= cycle_mode_in;
         enabled_ff    <= enabled_in;
         ack_en_ff     <= ack_en_in;
         count_ff      <= count_in;
         presc_ff      <= presc_in;
         pending_ff    <= pending_in;
      end
   end

   assign stat.pending      = pending_ff;
   assign stat.pending_next = pending_in;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the cartridge bank mapper: random and directed beats, scoreboard.
`default_nettype none
module testbench;
   import cbm_pkg::*;

   localparam int PRESC_PERIOD   = PRESCALE_PERIOD;
   localparam int PRESC_STEP     = PRESCALE_STEP;
   localparam int PHASES         = 10;
   localparam int PHASE_BEATS    = 135;
   localparam int PRESSURE_BEATS = 40;
   localparam int RSP_HOLD       = 80;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 40;

   localparam logic [1:0] CHR_KIND_ABSENT = 2'd2;
   localparam logic [1:0] CHR_KIND_SPARE  = 2'd3;

   class mapper_scoreboard;
      logic [2:0]  a0_pin, a1_pin;
      logic [5:0]  prg_banks;
      logic [1:0]  chr_kind;
      logic        prg_mode;
      logic [4:0]  prg_bank [2];
      logic [1:0]  mirroring;
      logic [7:0]  chr_bank [CHR_BANKS];
      logic [7:0]  irq_latch, irq_count;
      logic        irq_cycle_mode, irq_enabled, irq_ack_enable, irq_pending;
      int          irq_prescaler;
      cbm_rsp_type expected_maps [$];
      int          mismatches, checked, irq_seen;

      function new();
         a0_pin    = 3'd0;
         a1_pin    = 3'd1;
         prg_banks = 6'd32;
         chr_kind  = CHR_KIND_ROM;
         prg_mode  = 1'b0;
         prg_bank[0] = '0;
         prg_bank[1] = '0;
         mirroring = MIR_VERT;
         foreach (chr_bank[i]) chr_bank[i] = '0;
         irq_latch = '0;
         irq_count = '0;
         irq_cycle_mode = 1'b0;
         irq_enabled    = 1'b0;
         irq_ack_enable = 1'b0;
         irq_pending    = 1'b0;
         irq_prescaler  = 0;
         mismatches = 0;
         checked    = 0;
         irq_seen   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_A0_PIN:    a0_pin    = value[2:0];
            CSR_A1_PIN:    a1_pin    = value[2:0];
            CSR_PRG_BANKS: prg_banks = value;
            default:       chr_kind  = value[1:0];
         endcase
      endfunction

      function void step_counter();
         if (irq_count == 8'hff) begin
            irq_count   = irq_latch;
            irq_pending = 1'b1;
         end else begin
            irq_count = irq_count + 8'd1;
         end
      endfunction

      function void run_tick();
         if (!irq_enabled) return;
         if (!irq_cycle_mode) begin
            irq_prescaler -= PRESC_STEP;
            if (irq_prescaler <= 0) begin
               irq_prescaler += PRESC_PERIOD;
               if (irq_prescaler < -512) irq_prescaler = -512;
               step_counter();
            end
         end else begin
            step_counter();
         end
      endfunction

      function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
         logic [1:0] sel;
         logic [3:0] page, chr_page;
         logic [2:0] idx;
         sel      = {addr[a1_pin], addr[a0_pin]};
         page     = addr[15:12];
         chr_page = page - PAGE_CHR_FIRST;
         idx      = {chr_page[1:0], sel[1]};
         case (page)
            PAGE_PRG0: prg_bank[0] = data[4:0];
            PAGE_MIRROR: begin
               if (!sel[1]) mirroring = data[1:0];
               else prg_mode = data[1];
            end
            PAGE_PRG1: prg_bank[1] = data[4:0];
            PAGE_CHR_FIRST, PAGE_CHR_1, PAGE_CHR_2, PAGE_CHR_LAST: begin
               if (sel[0]) chr_bank[idx][7:4] = data[3:0];
               else chr_bank[idx][3:0] = data[3:0];
            end
            PAGE_IRQ: begin
               case (sel)
                  SEL_LATCH_LO: irq_latch[3:0] = data[3:0];
                  SEL_LATCH_HI: irq_latch[7:4] = data[3:0];
                  SEL_CTRL: begin
                     irq_ack_enable = data[0];
                     irq_enabled    = data[1];
                     irq_cycle_mode = data[2];
                     if (irq_enabled) begin
                        irq_count     = irq_latch;
                        irq_prescaler = PRESC_PERIOD;
                     end
                     irq_pending = 1'b0;
                  end
                  default: begin
                     irq_enabled = irq_ack_enable;
                     irq_pending = 1'b0;
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function logic [MAPPED_W-1:0] prg_address(logic [ADDR_W-1:0] addr);
         logic [4:0] last_bank, bank;
         last_bank = prg_banks[4:0] - 5'd1;
         case (addr[15:13])
            3'b100:  bank = prg_mode ? last_bank - 5'd1 : prg_bank[0];
            3'b101:  bank = prg_bank[1];
            3'b110:  bank = prg_mode ? prg_bank[0] : last_bank - 5'd1;
            default: bank = last_bank;
         endcase
         return {bank, addr[12:0]};
      endfunction

      function logic [MAPPED_W-1:0] ciram_address(logic [13:0] pa);
         case (mirroring)
            MIR_VERT: return {7'd0, pa[10], pa[9:0]};
            MIR_HORZ: return {7'd0, pa[11], pa[9:0]};
            MIR_ONE0: return {8'd0, pa[9:0]};
            default:  return {7'd0, 1'b1, pa[9:0]};
         endcase
      endfunction

      function cbm_rsp_type map_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                       logic [DATA_W-1:0] data);
         cbm_rsp_type r;
         logic [13:0] pa;
         r  = '0;
         pa = addr[13:0];
         case (cmd)
            CMD_TICK: run_tick();
            CMD_CPU_RD, CMD_CPU_WR: begin
               if (addr >= 16'h6000) begin
                  if (addr < 16'h8000) begin
                     r.target         = TGT_PRG_RAM;
                     r.mapped_address = {5'd0, addr[12:0]};
                  end else if (cmd == CMD_CPU_RD) begin
                     r.target         = TGT_PRG_ROM;
                     r.mapped_address = prg_address(addr);
                  end else begin
                     write_reg(addr, data);
                  end
               end
            end
            CMD_PPU_RD, CMD_PPU_WR: begin
               if (pa[13]) begin
                  r.target         = TGT_CIRAM;
                  r.mapped_address = ciram_address(pa);
               end else if (chr_kind == CHR_KIND_ROM && cmd == CMD_PPU_RD) begin
                  r.target         = TGT_CHR_ROM;
                  r.mapped_address = {chr_bank[pa[12:10]], pa[9:0]};
               end else if (chr_kind == CHR_KIND_RAM) begin
                  r.target         = TGT_CHR_RAM;
                  r.mapped_address = {chr_bank[pa[12:10]], pa[9:0]};
               end
            end
            default: ;
         endcase
         r.irq_line = irq_pending;
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                 logic [DATA_W-1:0] data);
         expected_maps.push_back(map_access(cmd, addr, data));
      endfunction

      function void complain(string field, int want, int got);
         if (mismatches < PRINT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         mismatches++;
      endfunction

      function void check_response(cbm_rsp_type got);
         cbm_rsp_type want;
         if (expected_maps.size() == 0) begin
            complain("unexpected beat, target", 0, got.target);
            return;
         end
         want = expected_maps.pop_front();
         checked++;
         if (got.irq_line === 1'b1) irq_seen++;
         if (got.target !== want.target) complain("target", want.target, got.target);
         if (got.mapped_address !== want.mapped_address)
            complain("mapped_address", want.mapped_address, got.mapped_address);
         if (got.irq_line !== want.irq_line) complain("irq_line", want.irq_line, got.irq_line);
      endfunction

      function int pending();
         return expected_maps.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   mapper_scoreboard sb = new();

   int beats_sent  = 0;
   int idle_cycles = 0;
   bit steady_req  = 1'b0;
   bit steady_rsp  = 1'b0;
   bit hold_rsp    = 1'b0;
   bit hold_active = 1'b0;

   cartridge_bank_mapper_with_irq_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin : watch
      cbm_rsp_type seen;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request(req_bus.cmd, req_bus.address, req_bus.data);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.target         = rsp_bus.target;
            seen.mapped_address = rsp_bus.mapped_address;
            seen.irq_line       = rsp_bus.irq_line;
            sb.check_response(seen);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin : rsp_sink
      int r;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            hold_active = 1'b1;
            repeat (RSP_HOLD) @(posedge clock);
            hold_active = 1'b0;
            hold_rsp    = 1'b0;
         end else if (steady_rsp) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end else if (r < 92) begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat ($urandom_range(8, 40)) @(posedge clock);
            end
         end
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady_req || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                            logic [DATA_W-1:0] data);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= cmd;
      req_bus.address <= addr;
      req_bus.data    <= data;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic release_req();
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   function logic [ADDR_W-1:0] reg_address(logic [3:0] page, logic [1:0] sel);
      logic [ADDR_W-1:0] a;
      a = {page, 12'($urandom)};
      a[sb.a1_pin] = sel[1];
      a[sb.a0_pin] = sel[0];
      return a;
   endfunction

   // One random sequence: IRQ programming runs, register writes or single accesses.
   task automatic random_sequence();
      int r, n;
      logic [DATA_W-1:0] ctrl;
      logic [3:0] nib;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         nib = ($urandom_range(0, 2) != 0) ? 4'hf : 4'($urandom);
         send_beat(CMD_CPU_WR, reg_address(PAGE_IRQ, SEL_LATCH_LO), 8'($urandom));
         send_beat(CMD_CPU_WR, reg_address(PAGE_IRQ, SEL_LATCH_HI), {4'($urandom), nib});
         ctrl = 8'($urandom);
         if ($urandom_range(0, 4) != 0) ctrl[1] = 1'b1;
         send_beat(CMD_CPU_WR, reg_address(PAGE_IRQ, SEL_CTRL), ctrl);
         if (ctrl[2]) n = $urandom_range(1, 40);
         else if ($urandom_range(0, 3) == 0) n = $urandom_range(100, 160);
         else n = $urandom_range(1, 30);
         repeat (n) send_beat(CMD_TICK, 16'($urandom), 8'($urandom));
         if ($urandom_range(0, 1) != 0)
            send_beat(CMD_CPU_WR, reg_address(PAGE_IRQ, SEL_ACK), 8'($urandom));
      end else if (r < 30) begin
         send_beat(CMD_CPU_WR, reg_address(4'($urandom_range(8, 15)), 2'($urandom)),
                   8'($urandom));
      end else if (r < 55) begin
         send_beat(CMD_TICK, 16'($urandom), 8'($urandom));
      end else if (r < 75) begin
         send_beat(CMD_CPU_RD, 16'($urandom), 8'($urandom));
      end else if (r < 80) begin
         send_beat(CMD_CPU_WR, 16'($urandom_range(0, 16'h7fff)), 8'($urandom));
      end else if (r < 92) begin
         send_beat(CMD_PPU_RD, 16'($urandom), 8'($urandom));
      end else if (r < 98) begin
         send_beat(CMD_PPU_WR, 16'($urandom), 8'($urandom));
      end else begin
         send_beat(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin : stimulus
      int start;
      logic [2:0] a0, a1;
      logic [5:0] banks;
      logic [1:0] kind;
      req_bus.valid   <= 1'b0;
      req_bus.cmd     <= CMD_TICK;
      req_bus.address <= '0;
      req_bus.data    <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_A0_PIN;
      csr_wr_data     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset settings: select bit 0 from A0, bit 1 from A1
      send_beat(CMD_CPU_RD, 16'h0000, 8'h00);
      send_beat(CMD_CPU_RD, 16'h5fff, 8'hff);
      send_beat(CMD_CPU_RD, 16'h6000, 8'h00);
      send_beat(CMD_CPU_WR, 16'h7fff, 8'hff);
      send_beat(CMD_CPU_WR, 16'h5fff, 8'hff);
      send_beat(CMD_CPU_WR, 16'h8000, 8'hff);
      send_beat(CMD_CPU_WR, 16'ha000, 8'h15);
      send_beat(CMD_CPU_WR, 16'h9002, 8'h02);
      send_beat(CMD_CPU_WR, 16'h9000, 8'h03);
      send_beat(CMD_CPU_RD, 16'h8000, 8'h00);
      send_beat(CMD_CPU_RD, 16'hc000, 8'h00);
      send_beat(CMD_CPU_RD, 16'hffff, 8'h00);
      send_beat(CMD_CPU_WR, 16'he003, 8'hff);
      send_beat(CMD_PPU_RD, 16'h1fff, 8'h00);
      send_beat(CMD_PPU_RD, 16'hfc00, 8'h00);
      send_beat(CMD_PPU_WR, 16'h0000, 8'hff);
      send_beat(CMD_CPU_WR, 16'hf000, 8'h0f);
      send_beat(CMD_CPU_WR, 16'hf001, 8'hff);
      send_beat(CMD_CPU_WR, 16'hf002, 8'h07);
      send_beat(CMD_TICK, 16'h0000, 8'h00);
      send_beat(CMD_TICK, 16'hffff, 8'hff);
      send_beat(CMD_CPU_WR, 16'hf003, 8'h00);
      send_beat(3'd7, 16'hffff, 8'hff);
      send_beat(CMD_CPU_WR, 16'hf002, 8'h00);
      release_req();

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin a0 = 3'd0; a1 = 3'd1; banks = 6'd32; kind = CHR_KIND_ROM;    end
            1: begin a0 = 3'd7; a1 = 3'd0; banks = 6'd1;  kind = CHR_KIND_RAM;    end
            2: begin a0 = 3'd2; a1 = 3'd3; banks = 6'd16; kind = CHR_KIND_ABSENT; end
            3: begin a0 = 3'd5; a1 = 3'd5; banks = 6'd2;  kind = CHR_KIND_SPARE;  end
            4: begin a0 = 3'd3; a1 = 3'd6; banks = 6'd31; kind = CHR_KIND_RAM;    end
            default: begin
               a0    = 3'($urandom);
               a1    = 3'($urandom);
               banks = 6'($urandom_range(1, 32));
               kind  = 2'($urandom_range(0, 3));
            end
         endcase
         write_csr(CSR_A0_PIN, {3'd0, a0});
         write_csr(CSR_A1_PIN, {3'd0, a1});
         write_csr(CSR_PRG_BANKS, banks);
         write_csr(CSR_CHR_KIND, {4'd0, kind});
         csr_wr_en <= 1'b0;

         steady_req = (phase == 5);
         steady_rsp = (phase == 5);
         start = beats_sent;
         while (beats_sent - start < PHASE_BEATS) random_sequence();
         release_req();

         if (phase == 2) begin
            // long receiver hold-off while the sender keeps offering back to back
            hold_rsp = 1'b1;
            wait (hold_active);
            @(posedge clock);
            steady_req = 1'b1;
            repeat (PRESSURE_BEATS) begin
               if ($urandom_range(0, 1) != 0) send_beat(CMD_TICK, 16'($urandom), 8'($urandom));
               else send_beat(CMD_CPU_RD, 16'($urandom), 8'($urandom));
            end
            steady_req = 1'b0;
            release_req();
         end
      end

      steady_rsp = 1'b0;
      drain();
      repeat (8) @(posedge clock);
      $display("summary: %0d beats sent over %0d register settings", beats_sent, PHASES);
      $display("summary: %0d results checked, %0d with the irq line high",
               sb.checked, sb.irq_seen);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0t: %0d mismatches, %0d results outstanding", $time, sb.mismatches,
                  sb.pending());
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/cbm_pkg.sv
src/cbm_if.sv
src/cbm_irq.sv
src/cartridge_bank_mapper_with_irq_top.sv
tb/testbench.sv
